@@ hw/rtl/fpc_pkg.sv @@
// Package for the Fermat primality check: widths, state and verdict codes, prime table.
package fpc_pkg;

  localparam int VAL_W = 63;
  localparam int TABLE_PRIMES = 169;
  localparam int IDX_W = $clog2(TABLE_PRIMES + 1);
  localparam logic [VAL_W-1:0] SMALL_LIMIT = 63'd1009;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [2:0] {
    V_BELOW_TWO  = 3'd0,
    V_SMALL_FAC  = 3'd1,
    V_GCD_FAC    = 3'd2,
    V_WITNESS    = 3'd3,
    V_TABLE      = 3'd4,
    V_PROBABLE   = 3'd5
  } verdict_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIAL,
    S_TRIAL_WAIT,
    S_GCD,
    S_GCD_WAIT,
    S_POW,
    S_MUL_WAIT,
    S_DONE
  } state_t;

  // Request to the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MOD,
    OP_MULMOD
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
    val_t a;
    val_t b;
    val_t n;
  } au_req_t;

  typedef struct packed {
    logic done;
    val_t res;
  } au_rsp_t;

  function automatic logic [9:0] prime_at(input logic [IDX_W-1:0] i);
    logic [9:0] p;
    case (i)
      8'd0: p = 10'd2; 8'd1: p = 10'd3; 8'd2: p = 10'd5; 8'd3: p = 10'd7;
      8'd4: p = 10'd11; 8'd5: p = 10'd13; 8'd6: p = 10'd17; 8'd7: p = 10'd19;
      8'd8: p = 10'd23; 8'd9: p = 10'd29; 8'd10: p = 10'd31; 8'd11: p = 10'd37;
      8'd12: p = 10'd41; 8'd13: p = 10'd43; 8'd14: p = 10'd47; 8'd15: p = 10'd53;
      8'd16: p = 10'd59; 8'd17: p = 10'd61; 8'd18: p = 10'd67; 8'd19: p = 10'd71;
      8'd20: p = 10'd73; 8'd21: p = 10'd79; 8'd22: p = 10'd83; 8'd23: p = 10'd89;
      8'd24: p = 10'd97; 8'd25: p = 10'd101; 8'd26: p = 10'd103; 8'd27: p = 10'd107;
      8'd28: p = 10'd109; 8'd29: p = 10'd113; 8'd30: p = 10'd127; 8'd31: p = 10'd131;
      8'd32: p = 10'd137; 8'd33: p = 10'd139; 8'd34: p = 10'd149; 8'd35: p = 10'd151;
      8'd36: p = 10'd157; 8'd37: p = 10'd163; 8'd38: p = 10'd167; 8'd39: p = 10'd173;
      8'd40: p = 10'd179; 8'd41: p = 10'd181; 8'd42: p = 10'd191; 8'd43: p = 10'd193;
      8'd44: p = 10'd197; 8'd45: p = 10'd199; 8'd46: p = 10'd211; 8'd47: p = 10'd223;
      8'd48: p = 10'd227; 8'd49: p = 10'd229; 8'd50: p = 10'd233; 8'd51: p = 10'd239;
      8'd52: p = 10'd241; 8'd53: p = 10'd251; 8'd54: p = 10'd257; 8'd55: p = 10'd263;
      8'd56: p = 10'd269; 8'd57: p = 10'd271; 8'd58: p = 10'd277; 8'd59: p = 10'd281;
      8'd60: p = 10'd283; 8'd61: p = 10'd293; 8'd62: p = 10'd307; 8'd63: p = 10'd311;
      8'd64: p = 10'd313; 8'd65: p = 10'd317; 8'd66: p = 10'd331; 8'd67: p = 10'd337;
      8'd68: p = 10'd347; 8'd69: p = 10'd349; 8'd70: p = 10'd353; 8'd71: p = 10'd359;
      8'd72: p = 10'd367; 8'd73: p = 10'd373; 8'd74: p = 10'd379; 8'd75: p = 10'd383;
      8'd76: p = 10'd389; 8'd77: p = 10'd397; 8'd78: p = 10'd401; 8'd79: p = 10'd409;
      8'd80: p = 10'd419; 8'd81: p = 10'd421; 8'd82: p = 10'd431; 8'd83: p = 10'd433;
      8'd84: p = 10'd439; 8'd85: p = 10'd443; 8'd86: p = 10'd449; 8'd87: p = 10'd457;
      8'd88: p = 10'd461; 8'd89: p = 10'd463; 8'd90: p = 10'd467; 8'd91: p = 10'd479;
      8'd92: p = 10'd487; 8'd93: p = 10'd491; 8'd94: p = 10'd499; 8'd95: p = 10'd503;
      8'd96: p = 10'd509; 8'd97: p = 10'd521; 8'd98: p = 10'd523; 8'd99: p = 10'd541;
      8'd100: p = 10'd547; 8'd101: p = 10'd557; 8'd102: p = 10'd563; 8'd103: p = 10'd569;
      8'd104: p = 10'd571; 8'd105: p = 10'd577; 8'd106: p = 10'd587; 8'd107: p = 10'd593;
      8'd108: p = 10'd599; 8'd109: p = 10'd601; 8'd110: p = 10'd607; 8'd111: p = 10'd613;
      8'd112: p = 10'd617; 8'd113: p = 10'd619; 8'd114: p = 10'd631; 8'd115: p = 10'd641;
      8'd116: p = 10'd643; 8'd117: p = 10'd647; 8'd118: p = 10'd653; 8'd119: p = 10'd659;
      8'd120: p = 10'd661; 8'd121: p = 10'd673; 8'd122: p = 10'd677; 8'd123: p = 10'd683;
      8'd124: p = 10'd691; 8'd125: p = 10'd701; 8'd126: p = 10'd709; 8'd127: p = 10'd719;
      8'd128: p = 10'd727; 8'd129: p = 10'd733; 8'd130: p = 10'd739; 8'd131: p = 10'd743;
      8'd132: p = 10'd751; 8'd133: p = 10'd757; 8'd134: p = 10'd761; 8'd135: p = 10'd769;
      8'd136: p = 10'd773; 8'd137: p = 10'd787; 8'd138: p = 10'd797; 8'd139: p = 10'd809;
      8'd140: p = 10'd811; 8'd141: p = 10'd821; 8'd142: p = 10'd823; 8'd143: p = 10'd827;
      8'd144: p = 10'd829; 8'd145: p = 10'd839; 8'd146: p = 10'd853; 8'd147: p = 10'd857;
      8'd148: p = 10'd859; 8'd149: p = 10'd863; 8'd150: p = 10'd877; 8'd151: p = 10'd881;
      8'd152: p = 10'd883; 8'd153: p = 10'd887; 8'd154: p = 10'd907; 8'd155: p = 10'd911;
      8'd156: p = 10'd919; 8'd157: p = 10'd929; 8'd158: p = 10'd937; 8'd159: p = 10'd941;
      8'd160: p = 10'd947; 8'd161: p = 10'd953; 8'd162: p = 10'd967; 8'd163: p = 10'd971;
      8'd164: p = 10'd977; 8'd165: p = 10'd983; 8'd166: p = 10'd991; 8'd167: p = 10'd997;
      8'd168: p = 10'd1009;
      default: p = 10'd2;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/fpc_arith.sv @@
// Shared arithmetic unit: restoring a mod n and shift-add a*b mod n, one bit a cycle.
module fpc_arith (
  input  logic            clk,
  input  logic            rst_n,
  input  fpc_pkg::au_req_t req,
  output fpc_pkg::au_rsp_t rsp
);

  localparam int W = fpc_pkg::VAL_W;
  localparam int CW = $clog2(W + 2);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  fpc_pkg::op_t  op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  n_r, n_nxt;

  logic [W:0] rem_sh;
  logic [W:0] sum;
  logic [W:0] dbl;
  logic [W-1:0] acc_add;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    n_nxt    = n_r;
    rem_sh   = '0;
    sum      = '0;
    dbl      = '0;
    acc_add  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = req.a;
      y_nxt    = req.b;
      n_nxt    = req.n;
    end else if (busy_r) begin
      if (op_r == fpc_pkg::OP_MOD) begin
        // Restoring division: shift the dividend bits into the remainder.
        rem_sh  = {acc_r, x_r[W-1]};
        x_nxt   = {x_r[W-2:0], 1'b0};
        if (rem_sh >= {1'b0, n_r}) begin
          rem_sh = rem_sh - {1'b0, n_r};
        end
        acc_nxt = rem_sh[W-1:0];
      end else begin
        // Operands are already below n, so one subtract reduces each sum.
        if (y_r[0]) begin
          sum = {1'b0, acc_r} + {1'b0, x_r};
          if (sum >= {1'b0, n_r}) begin
            sum = sum - {1'b0, n_r};
          end
          acc_add = sum[W-1:0];
        end
        acc_nxt = acc_add;
        dbl = {x_r, 1'b0};
        if (dbl >= {1'b0, n_r}) begin
          dbl = dbl - {1'b0, n_r};
        end
        x_nxt = dbl[W-1:0];
        y_nxt = {1'b0, y_r[W-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    n_r   <= n_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

@@ hw/rtl/fermat_primality_check_top.sv @@
// Top level: sequencer for trial division, gcd and modular power on one arithmetic unit.
// One item at a time; each reduction or modular product is a separate request to the unit.
// Work per item: one reduction per table prime tried (up to 169), one per gcd step (up to about 90),
// and a base reduction plus up to 126 products.
// A new item is accepted only once the verdict is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears out_valid.
module fermat_primality_check_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [62:0] in_candidate,
  input  logic [62:0] in_witness_base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_verdict
);

  localparam int W = fpc_pkg::VAL_W;
  localparam int IW = fpc_pkg::IDX_W;
  localparam int KW = $clog2(W + 1);

  fpc_pkg::state_t   state_r, state_nxt;
  fpc_pkg::au_req_t  req;
  fpc_pkg::au_rsp_t  rsp;

  logic [W-1:0]  cand_r, cand_nxt;
  logic [W-1:0]  ga_r, ga_nxt;
  logic [W-1:0]  gb_r, gb_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sq_r, sq_nxt;
  logic [W-1:0]  exp_r, exp_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          phase_r, phase_nxt;   // 0: multiply into acc, 1: square
  logic [IW-1:0] idx_r, idx_nxt;
  logic [2:0]    verdict_r, verdict_nxt;
  logic [W-1:0]  prime_w;

  fpc_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign prime_w = W'(fpc_pkg::prime_at(idx_r));

  always_comb begin
    state_nxt   = state_r;
    cand_nxt    = cand_r;
    ga_nxt      = ga_r;
    gb_nxt      = gb_r;
    acc_nxt     = acc_r;
    sq_nxt      = sq_r;
    exp_nxt     = exp_r;
    k_nxt       = k_r;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    verdict_nxt = verdict_r;
    req.start   = 1'b0;
    req.op      = fpc_pkg::OP_MOD;
    req.a       = cand_r;
    req.b       = '0;
    req.n       = prime_w;
    case (state_r)
      fpc_pkg::S_IDLE: begin
        if (in_valid) begin
          cand_nxt = in_candidate;
          ga_nxt   = in_candidate;
          gb_nxt   = in_witness_base;
          sq_nxt   = in_witness_base;
          idx_nxt  = '0;
          if (in_candidate < W'(2)) begin
            verdict_nxt = fpc_pkg::V_BELOW_TWO;
            state_nxt   = fpc_pkg::S_DONE;
          end else begin
            state_nxt = fpc_pkg::S_TRIAL;
          end
        end
      end
      fpc_pkg::S_TRIAL: begin
        if (cand_r != prime_w) begin
          req.start = 1'b1;
          state_nxt = fpc_pkg::S_TRIAL_WAIT;
        end else if (idx_r == IW'(fpc_pkg::TABLE_PRIMES - 1)) begin
          verdict_nxt = fpc_pkg::V_TABLE;
          state_nxt   = fpc_pkg::S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      fpc_pkg::S_TRIAL_WAIT: begin
        if (rsp.done) begin
          if (rsp.res == '0) begin
            verdict_nxt = fpc_pkg::V_SMALL_FAC;
            state_nxt   = fpc_pkg::S_DONE;
          end else if (idx_r == IW'(fpc_pkg::TABLE_PRIMES - 1)) begin
            if (cand_r <= fpc_pkg::SMALL_LIMIT) begin
              verdict_nxt = fpc_pkg::V_TABLE;
              state_nxt   = fpc_pkg::S_DONE;
            end else begin
              state_nxt = fpc_pkg::S_GCD;
            end
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = fpc_pkg::S_TRIAL;
          end
        end
      end
      fpc_pkg::S_GCD: begin
        if (gb_r == '0) begin
          if (ga_r != W'(1)) begin
            verdict_nxt = fpc_pkg::V_GCD_FAC;
            state_nxt   = fpc_pkg::S_DONE;
          end else begin
            acc_nxt   = W'(1);
            exp_nxt   = cand_r - W'(1);
            // Reduce the base below the candidate before squaring.
            req.start = 1'b1;
            req.op    = fpc_pkg::OP_MOD;
            req.a     = sq_r;
            req.n     = cand_r;
            state_nxt = fpc_pkg::S_MUL_WAIT;
            phase_nxt = 1'b1;
            k_nxt     = KW'(W);
          end
        end else begin
          req.start = 1'b1;
          req.op    = fpc_pkg::OP_MOD;
          req.a     = ga_r;
          req.n     = gb_r;
          state_nxt = fpc_pkg::S_GCD_WAIT;
        end
      end
      fpc_pkg::S_GCD_WAIT: begin
        if (rsp.done) begin
          ga_nxt    = gb_r;
          gb_nxt    = rsp.res;
          state_nxt = fpc_pkg::S_GCD;
        end
      end
      fpc_pkg::S_POW: begin
        if (k_r == KW'(W)) begin
          verdict_nxt = (acc_r == W'(1)) ? fpc_pkg::V_PROBABLE : fpc_pkg::V_WITNESS;
          state_nxt   = fpc_pkg::S_DONE;
        end else if (!phase_r) begin
          if (exp_r[0]) begin
            req.start = 1'b1;
            req.op    = fpc_pkg::OP_MULMOD;
            req.a     = acc_r;
            req.b     = sq_r;
            req.n     = cand_r;
            state_nxt = fpc_pkg::S_MUL_WAIT;
          end else begin
            phase_nxt = 1'b1;
          end
        end else begin
          req.start = 1'b1;
          req.op    = fpc_pkg::OP_MULMOD;
          req.a     = sq_r;
          req.b     = sq_r;
          req.n     = cand_r;
          state_nxt = fpc_pkg::S_MUL_WAIT;
        end
      end
      fpc_pkg::S_MUL_WAIT: begin
        if (rsp.done) begin
          state_nxt = fpc_pkg::S_POW;
          if (k_r == KW'(W)) begin
            // Base reduction finished: start the exponent walk.
            sq_nxt    = rsp.res;
            k_nxt     = '0;
            phase_nxt = 1'b0;
          end else if (!phase_r) begin
            acc_nxt   = rsp.res;
            phase_nxt = 1'b1;
          end else begin
            sq_nxt    = rsp.res;
            phase_nxt = 1'b0;
            exp_nxt   = {1'b0, exp_r[W-1:1]};
            // Stop the walk once the remaining exponent bits are all zero.
            k_nxt     = (exp_r[W-1:1] == '0) ? KW'(W) : k_r + 1'b1;
          end
        end
      end
      fpc_pkg::S_DONE: begin
        if (!out_stall) begin
          state_nxt = fpc_pkg::S_IDLE;
        end
      end
      default: state_nxt = fpc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cand_r    <= cand_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    exp_r     <= exp_nxt;
    k_r       <= k_nxt;
    phase_r   <= phase_nxt;
    idx_r     <= idx_nxt;
    verdict_r <= verdict_nxt;
  end

  assign in_stall    = (state_r != fpc_pkg::S_IDLE);
  assign out_valid   = (state_r == fpc_pkg::S_DONE);
  assign out_verdict = verdict_r;

endmodule

@@ bench/tb_fermat_primality_check_top.sv @@
// Testbench for the Fermat primality check: queued driver, clocked monitor and verdict predictor.
module tb_fermat_primality_check_top;

  typedef struct {
    logic [62:0] cand;
    logic [62:0] base;
    bit          drain;
  } test_item_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int LONG_HOLD = 30000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [62:0] in_candidate;
  logic [62:0] in_witness_base;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_verdict;

  test_item_t          pending_items[$];
  fpc_pkg::verdict_t   expected_verdicts[$];
  int          small_primes[$];
  int          mismatch_count;
  int          verdicts_seen;
  int          idle_cycles;
  bit          in_taken;
  int          gap_left;
  int          burst_left;
  int          hold_left;
  bit          hold_done;
  int          stall_mode;
  int          mode_left;

  fermat_primality_check_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_candidate(in_candidate), .in_witness_base(in_witness_base),
    .out_valid(out_valid), .out_stall(out_stall), .out_verdict(out_verdict)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // (x * y) mod n by shift-add; values below 2^63 so the sums fit in 64 bits.
  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] acc;
    acc = 0;
    for (int k = 0; k < 64; k++) begin
      if (y[k]) acc = (acc + x) % n;
      x = (x << 1) % n;
    end
    return acc;
  endfunction

  function automatic fpc_pkg::verdict_t primality_verdict(logic [62:0] cand_in,
                                                          logic [62:0] base_in);
    logic [63:0] cand, base, a, b, r, acc, sq, e;
    cand = {1'b0, cand_in};
    base = {1'b0, base_in};
    if (cand < 2) return fpc_pkg::V_BELOW_TWO;
    foreach (small_primes[i])
      if (cand != small_primes[i] && cand % small_primes[i] == 0) return fpc_pkg::V_SMALL_FAC;
    if (cand <= 1009) return fpc_pkg::V_TABLE;
    a = cand;
    b = base;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    if (a != 1) return fpc_pkg::V_GCD_FAC;
    acc = 1;
    sq = base;
    e = cand - 1;
    for (int k = 0; k < 64; k++) begin
      if (e[k]) acc = mul_mod(acc, sq, cand);
      sq = mul_mod(sq, sq, cand);
    end
    return (acc != 1) ? fpc_pkg::V_WITNESS : fpc_pkg::V_PROBABLE;
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  task automatic add_item(logic [62:0] cand, logic [62:0] base, bit drain = 0);
    test_item_t t;
    t.cand = cand;
    t.base = base;
    t.drain = drain;
    pending_items.push_back(t);
  endtask

  // Driver: bursts of items separated by random gaps; a drain item waits for an empty pipe.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_candidate <= '0;
      in_witness_base <= '0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() == 0 ||
                 (pending_items[0].drain && (expected_verdicts.size() != 0 || in_valid))) begin
      in_valid <= 1'b0;
    end else begin
      test_item_t t;
      t = pending_items.pop_front();
      in_valid <= 1'b1;
      in_candidate <= t.cand;
      in_witness_base <= t.base;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(6, 1);
        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver: stall pattern changes every so often, with one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && verdicts_seen == 30) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2);
        mode_left <= $urandom_range(200, 20);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(1) == 0);
        default: out_stall <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // Monitor: predicts on every accepted item and checks every accepted verdict.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_verdicts.push_back(primality_verdict(in_candidate, in_witness_base));
      if (out_valid && !out_stall) begin
        verdicts_seen <= verdicts_seen + 1;
        if (expected_verdicts.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("Unexpected verdict %0d", out_verdict);
        end else begin
          fpc_pkg::verdict_t want;
          want = expected_verdicts.pop_front();
          if (out_verdict !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("Verdict mismatch: expected %0d, got %0d", want, out_verdict);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [62:0] primes[9];
    logic [62:0] c, b;
    int sel;
    primes = '{63'd1013, 63'd65537, 63'd1000003, 63'd1000033, 63'd2147483647,
               63'd4294967291, 63'd999999937, 63'd2305843009213693951,
               63'd9223372036854775783};
    for (int p = 2; p <= 1009 && small_primes.size() < fpc_pkg::TABLE_PRIMES; p++) begin
      bit is_p;
      is_p = 1;
      for (int d = 2; d * d <= p; d++) if (p % d == 0) is_p = 0;
      if (is_p) small_primes.push_back(p);
    end
    mismatch_count = 0;
    verdicts_seen = 0;
    idle_cycles = 0;
    in_taken = 0;
    gap_left = 0;
    burst_left = 1;
    hold_left = 0;
    hold_done = 0;
    stall_mode = 0;
    mode_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_candidate = '0;
    in_witness_base = '0;
    out_stall = 1'b0;

    // Directed items: below two, table edges, special bases and the field extremes.
    add_item(0, 2);
    add_item(1, 2);
    add_item(2, 2);
    add_item(3, 2);
    add_item(4, 2);
    add_item(997, 5);
    add_item(1009, 7);
    add_item(1008, 7);
    add_item(1011, 2);
    add_item(1013, 2);
    add_item(1013, 0);
    add_item(1013, 1);
    add_item(1013, 2026);
    add_item(1013, 1013);
    add_item(63'h7FFFFFFFFFFFFFFF, 63'h7FFFFFFFFFFFFFFF);
    add_item(63'd9223372036854775783, 2, 1);
    add_item(63'd9223372036854775783, 63'h7FFFFFFFFFFFFFFF);
    add_item(63'd1000036000099, 2);
    add_item(63'd1000036000099, 1000003);
    // A composite with the base minus one passes the Fermat test.
    add_item(63'd1000036000099, 63'd1000036000098);
    add_item(63'd2305843009213693951, 3);

    for (int i = 0; i < 100; i++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        c = primes[$urandom_range(8)];
        b = 63'(({1'b0, rand63()} % {1'b0, c - 63'd3}) + 64'd2);
      end else if (sel < 45) begin
        c = primes[$urandom_range(6)] * primes[$urandom_range(6)];
        b = ($urandom_range(3) == 0) ? primes[$urandom_range(6)]
                                     : (rand63() % (c - 63'd3)) + 63'd2;
      end else if (sel < 70) begin
        c = rand63();
        b = rand63();
      end else begin
        c = 63'($urandom_range(1200));
        b = ($urandom_range(1) == 0) ? rand63() : 63'($urandom_range(1200, 2));
      end
      add_item(c, b, i == 60);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_verdicts.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
